[rtl/assert_macros.svh]
// Assertion macros used by the RTL parser module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/drap_pkg.sv]
// Types and constants of the DNS response A-record parser.
`default_nettype none

package drap_pkg;

    localparam int MAX_PACKET_BYTES = 512;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

    localparam int HEADER_BYTES   = 12;
    localparam int RR_FIXED_BYTES = 10;
    localparam int QUESTION_TAIL  = 4;
    localparam int FIXED_IDX_W    = $clog2(RR_FIXED_BYTES);

    localparam logic [7:0]  PTR_MASK   = 8'hC0;
    localparam logic [7:0]  QR_MASK    = 8'h80;
    localparam logic [7:0]  RCODE_MASK = 8'h0F;
    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] CLASS_IN   = 16'd1;

    localparam int CFG_DATA_W = 16;

    typedef enum logic [0:0] {
        CFG_EXPECTED_ID = 1'b0,
        CFG_ID_WINDOW   = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_FOUND      = 3'd0,
        ST_TOO_SHORT  = 3'd1,
        ST_NOT_ANSWER = 3'd2,
        ST_ID_MISMATCH = 3'd3,
        ST_NO_A_RECORD = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_NAME    = 4'd1,
        PH_LABEL   = 4'd2,
        PH_PTR     = 4'd3,
        PH_QFIXED  = 4'd4,
        PH_AFIXED  = 4'd5,
        PH_RDSKIP  = 4'd6,
        PH_CAPTURE = 4'd7,
        PH_DONE    = 4'd8
    } phase_t;

endpackage

`default_nettype wire

[rtl/drap_if.sv]
// Valid/ready channel interfaces for message bytes and parse results.
`default_nettype none

interface drap_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface drap_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] ipv4_address;
    logic [15:0] response_id;

    modport source (output valid, output status, output ipv4_address, output response_id,
                    input ready);
    modport sink   (input valid, input status, input ipv4_address, input response_id,
                    output ready);
endinterface

`default_nettype wire

[rtl/dns_response_a_record_parser_core.sv]
// Top level: byte-serial DNS response parser that extracts the first A record.
`default_nettype none
`include "assert_macros.svh"

// Takes one response byte per cycle on byte_in, last_byte marking the end of
// the message, and returns one transaction on result_out for every message:
// status, the IPv4 address of the first type A / class IN answer, and the id
// from the header. Each byte is parsed in the cycle it is accepted by a
// single state update. The result register sits between the parser and the
// result channel and presents the result the cycle after the final byte is
// accepted. While that result waits and result_out.ready is low, byte_in is
// held off, whether or not the next byte ends a message. With result_out
// ready, the sustained rate is one byte per cycle. Bytes beyond
// MAX_PACKET_BYTES are not parsed, but their last_byte still ends the message.
// The user must write expected_id and id_window via the cfg port only while idle; the block does not enforce it.
module dns_response_a_record_parser_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire drap_pkg::cfg_index_t          cfg_index,
    input  wire logic [drap_pkg::CFG_DATA_W-1:0] cfg_data,
    drap_byte_if.sink                          byte_in,
    drap_result_if.source                      result_out
);
    import drap_pkg::*;

    logic [15:0] expected_id_reg;
    logic [1:0]  id_window_reg;

    logic [POS_W-1:0]       byte_position_reg, byte_position_next;
    phase_t                 parse_phase_reg, parse_phase_next;
    logic [15:0]            header_id_reg, header_id_next;
    logic                   header_flags_ok_reg, header_flags_ok_next;
    logic [15:0]            questions_left_reg, questions_left_next;
    logic [15:0]            answers_left_reg, answers_left_next;
    logic [15:0]            skip_count_reg, skip_count_next;
    logic [15:0]            record_type_reg, record_type_next;
    logic [15:0]            record_class_reg, record_class_next;
    logic [31:0]            captured_address_reg, captured_address_next;
    logic                   found_flag_reg, found_flag_next;
    logic [FIXED_IDX_W-1:0] fixed_index_reg, fixed_index_next;

    logic        out_valid_reg;
    status_t     status_reg;
    logic [31:0] ipv4_address_reg;
    logic [15:0] response_id_reg;

    logic        accept;
    logic        in_range;
    logic [7:0]  b;
    logic [15:0] skip_dec;
    logic [15:0] answers_dec;
    logic [15:0] skip_shift;
    logic        id_ok_cur;
    logic        id_ok_next;
    status_t     status_next;

    assign byte_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;
    assign b             = byte_in.data_byte;
    assign in_range      = byte_position_reg < POS_W'(MAX_PACKET_BYTES);
    assign skip_dec      = skip_count_reg - 16'd1;
    assign answers_dec   = answers_left_reg - 16'd1;
    assign skip_shift    = {skip_count_reg[7:0], b};
    assign id_ok_cur     = (expected_id_reg - header_id_reg) <= {14'd0, id_window_reg};
    assign id_ok_next    = (expected_id_reg - header_id_next) <= {14'd0, id_window_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= '0;
            id_window_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_ID: expected_id_reg <= cfg_data;
                CFG_ID_WINDOW:   id_window_reg   <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        byte_position_next    = byte_position_reg;
        parse_phase_next      = parse_phase_reg;
        header_id_next        = header_id_reg;
        header_flags_ok_next  = header_flags_ok_reg;
        questions_left_next   = questions_left_reg;
        answers_left_next     = answers_left_reg;
        skip_count_next       = skip_count_reg;
        record_type_next      = record_type_reg;
        record_class_next     = record_class_reg;
        captured_address_next = captured_address_reg;
        found_flag_next       = found_flag_reg;
        fixed_index_next      = fixed_index_reg;

        if (in_range)
        begin
            byte_position_next = byte_position_reg + POS_W'(1);
            unique case (parse_phase_reg)
                PH_HEADER:
                begin
                    priority if (byte_position_reg < POS_W'(2))
                        header_id_next = {header_id_reg[7:0], b};
                    else if (byte_position_reg == POS_W'(2))
                        header_flags_ok_next = (b & QR_MASK) != 8'd0;
                    else if (byte_position_reg == POS_W'(3))
                        header_flags_ok_next = header_flags_ok_reg && ((b & RCODE_MASK) == 8'd0);
                    else if (byte_position_reg == POS_W'(4) || byte_position_reg == POS_W'(5))
                        questions_left_next = {questions_left_reg[7:0], b};
                    else if (byte_position_reg == POS_W'(6) || byte_position_reg == POS_W'(7))
                        answers_left_next = {answers_left_reg[7:0], b};
                    else
                        ;
                    if (byte_position_reg == POS_W'(HEADER_BYTES - 1))
                    begin
                        header_flags_ok_next = header_flags_ok_reg && (answers_left_reg != 16'd0);
                        parse_phase_next = (header_flags_ok_next && id_ok_cur) ? PH_NAME : PH_DONE;
                    end
                end
                PH_NAME, PH_PTR:
                begin
                    if (parse_phase_reg == PH_PTR || b == 8'd0)
                    begin
                        if (questions_left_reg != 16'd0)
                        begin
                            parse_phase_next = PH_QFIXED;
                            skip_count_next  = 16'(QUESTION_TAIL);
                        end
                        else
                        begin
                            parse_phase_next  = PH_AFIXED;
                            fixed_index_next  = '0;
                            record_type_next  = '0;
                            record_class_next = '0;
                            skip_count_next   = '0;
                        end
                    end
                    else if ((b & PTR_MASK) == PTR_MASK)
                        parse_phase_next = PH_PTR;
                    else
                    begin
                        skip_count_next  = {8'd0, b};
                        parse_phase_next = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 16'd0)
                        parse_phase_next = PH_NAME;
                end
                PH_QFIXED:
                begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        questions_left_next = questions_left_reg - 16'd1;
                        parse_phase_next    = PH_NAME;
                    end
                end
                PH_AFIXED:
                begin
                    priority if (fixed_index_reg < FIXED_IDX_W'(2))
                        record_type_next = {record_type_reg[7:0], b};
                    else if (fixed_index_reg < FIXED_IDX_W'(4))
                        record_class_next = {record_class_reg[7:0], b};
                    else if (fixed_index_reg >= FIXED_IDX_W'(8))
                        skip_count_next = skip_shift;
                    else
                        ;
                    fixed_index_next = fixed_index_reg + FIXED_IDX_W'(1);
                    if (fixed_index_reg == FIXED_IDX_W'(RR_FIXED_BYTES - 1))
                    begin
                        fixed_index_next = '0;
                        priority if (record_type_reg == TYPE_A && record_class_reg == CLASS_IN)
                        begin
                            captured_address_next = '0;
                            skip_count_next       = 16'd4;
                            parse_phase_next      = PH_CAPTURE;
                        end
                        else if (skip_shift != 16'd0)
                            parse_phase_next = PH_RDSKIP;
                        else
                        begin
                            answers_left_next = answers_dec;
                            parse_phase_next  = (answers_dec != 16'd0) ? PH_NAME : PH_DONE;
                        end
                    end
                end
                PH_RDSKIP:
                begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        answers_left_next = answers_dec;
                        parse_phase_next  = (answers_dec != 16'd0) ? PH_NAME : PH_DONE;
                    end
                end
                PH_CAPTURE:
                begin
                    captured_address_next = {captured_address_reg[23:0], b};
                    skip_count_next       = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        found_flag_next  = 1'b1;
                        parse_phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        priority if (byte_position_next < POS_W'(HEADER_BYTES))
            status_next = ST_TOO_SHORT;
        else if (!header_flags_ok_next)
            status_next = ST_NOT_ANSWER;
        else if (!id_ok_next)
            status_next = ST_ID_MISMATCH;
        else if (found_flag_next)
            status_next = ST_FOUND;
        else
            status_next = ST_NO_A_RECORD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg    <= '0;
            parse_phase_reg      <= PH_HEADER;
            header_id_reg        <= '0;
            header_flags_ok_reg  <= 1'b0;
            questions_left_reg   <= '0;
            answers_left_reg     <= '0;
            skip_count_reg       <= '0;
            record_type_reg      <= '0;
            record_class_reg     <= '0;
            captured_address_reg <= '0;
            found_flag_reg       <= 1'b0;
            fixed_index_reg      <= '0;
        end
        else if (accept)
        begin
            if (byte_in.last_byte)
            begin
                byte_position_reg    <= '0;
                parse_phase_reg      <= PH_HEADER;
                header_id_reg        <= '0;
                header_flags_ok_reg  <= 1'b0;
                questions_left_reg   <= '0;
                answers_left_reg     <= '0;
                skip_count_reg       <= '0;
                record_type_reg      <= '0;
                record_class_reg     <= '0;
                captured_address_reg <= '0;
                found_flag_reg       <= 1'b0;
                fixed_index_reg      <= '0;
            end
            else
            begin
                byte_position_reg    <= byte_position_next;
                parse_phase_reg      <= parse_phase_next;
                header_id_reg        <= header_id_next;
                header_flags_ok_reg  <= header_flags_ok_next;
                questions_left_reg   <= questions_left_next;
                answers_left_reg     <= answers_left_next;
                skip_count_reg       <= skip_count_next;
                record_type_reg      <= record_type_next;
                record_class_reg     <= record_class_next;
                captured_address_reg <= captured_address_next;
                found_flag_reg       <= found_flag_next;
                fixed_index_reg      <= fixed_index_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && byte_in.last_byte)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && byte_in.last_byte)
        begin
            status_reg       <= status_next;
            ipv4_address_reg <= (status_next == ST_FOUND) ? captured_address_next : 32'd0;
            response_id_reg  <= header_id_next;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.status       = status_reg;
    assign result_out.ipv4_address = ipv4_address_reg;
    assign result_out.response_id  = response_id_reg;

    `ASSERT_IMPLY(a_stall_blocks_input, clk, rst_n,
                  out_valid_reg && !result_out.ready, !byte_in.ready,
                  "byte accepted while result stalled")
    `ASSERT_NEXT(a_last_gives_result, clk, rst_n,
                 accept && byte_in.last_byte, out_valid_reg,
                 "final byte produced no result")
    `ASSERT_NEXT(a_last_clears_state, clk, rst_n,
                 accept && byte_in.last_byte,
                 parse_phase_reg == PH_HEADER && byte_position_reg == '0,
                 "message state not cleared")
    `ASSERT_IMPLY(a_address_zero_unless_found, clk, rst_n,
                  out_valid_reg && status_reg != ST_FOUND, ipv4_address_reg == 32'd0,
                  "address set without A record")
    `ASSERT_ALWAYS(a_fixed_index_range, clk, rst_n,
                   fixed_index_reg < FIXED_IDX_W'(RR_FIXED_BYTES),
                   "record fixed index out of range")

endmodule

`default_nettype wire

[verif/dns_response_a_record_parser_core_tb.sv]
// Testbench for the DNS response A-record parser: random responses checked against a predictor.
`timescale 1ns / 100ps

module dns_response_a_record_parser_core_tb;
    import drap_pkg::*;

    localparam int PHASES       = 6;
    localparam int PHASE_BYTES  = 150;
    localparam int MIN_MESSAGES = 2;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    localparam int STALL_LIMIT  = 4000;

    typedef struct {
        status_t     status;
        logic [31:0] address;
        logic [15:0] id;
    } a_lookup_t;

    class a_record_board;
        logic [15:0] expected_id;
        logic [1:0]  id_window;
        logic [9:0]  position;
        phase_t      phase;
        logic [15:0] hdr_id;
        logic        flags_ok;
        logic [15:0] questions_left;
        logic [15:0] answers_left;
        logic [15:0] skip_count;
        logic [15:0] rec_type;
        logic [15:0] rec_class;
        logic [31:0] address;
        logic        found;
        logic [3:0]  fixed_index;
        a_lookup_t   lookups[$];
        int          errors;

        function new();
            expected_id = '0;
            id_window   = '0;
            errors      = 0;
            clear_message();
        endfunction

        function void clear_message();
            position       = '0;
            phase          = PH_HEADER;
            hdr_id         = '0;
            flags_ok       = 1'b0;
            questions_left = '0;
            answers_left   = '0;
            skip_count     = '0;
            rec_type       = '0;
            rec_class      = '0;
            address        = '0;
            found          = 1'b0;
            fixed_index    = '0;
        endfunction

        function bit id_ok();
            logic [15:0] distance;
            distance = expected_id - hdr_id;
            return distance <= {14'b0, id_window};
        endfunction

        function void name_done();
            if (questions_left != 0)
            begin
                phase      = PH_QFIXED;
                skip_count = 16'(QUESTION_TAIL);
            end
            else
            begin
                phase       = PH_AFIXED;
                fixed_index = '0;
                rec_type    = '0;
                rec_class   = '0;
                skip_count  = '0;
            end
        endfunction

        function void record_done();
            answers_left = answers_left - 16'd1;
            phase = (answers_left != 0) ? PH_NAME : PH_DONE;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            a_lookup_t res;
            if (position < MAX_PACKET_BYTES)
            begin
                case (phase)
                    PH_HEADER:
                    begin
                        if (position < 2)
                            hdr_id = {hdr_id[7:0], b};
                        else if (position == 2)
                            flags_ok = (b & QR_MASK) != 0;
                        else if (position == 3)
                            flags_ok = flags_ok && ((b & RCODE_MASK) == 0);
                        else if (position == 4 || position == 5)
                            questions_left = {questions_left[7:0], b};
                        else if (position == 6 || position == 7)
                            answers_left = {answers_left[7:0], b};
                        if (position == HEADER_BYTES - 1)
                        begin
                            flags_ok = flags_ok && (answers_left != 0);
                            phase = (flags_ok && id_ok()) ? PH_NAME : PH_DONE;
                        end
                    end
                    PH_NAME:
                    begin
                        if (b == 0)
                            name_done();
                        else if ((b & PTR_MASK) == PTR_MASK)
                            phase = PH_PTR;
                        else
                        begin
                            skip_count = {8'h00, b};
                            phase      = PH_LABEL;
                        end
                    end
                    PH_LABEL:
                    begin
                        skip_count = skip_count - 16'd1;
                        if (skip_count == 0)
                            phase = PH_NAME;
                    end
                    PH_PTR:
                        name_done();
                    PH_QFIXED:
                    begin
                        skip_count = skip_count - 16'd1;
                        if (skip_count == 0)
                        begin
                            questions_left = questions_left - 16'd1;
                            phase = PH_NAME;
                        end
                    end
                    PH_AFIXED:
                    begin
                        if (fixed_index < 2)
                            rec_type = {rec_type[7:0], b};
                        else if (fixed_index < 4)
                            rec_class = {rec_class[7:0], b};
                        else if (fixed_index >= 8)
                            skip_count = {skip_count[7:0], b};
                        fixed_index = fixed_index + 4'd1;
                        if (fixed_index >= RR_FIXED_BYTES)
                        begin
                            fixed_index = '0;
                            if (rec_type == TYPE_A && rec_class == CLASS_IN)
                            begin
                                address    = '0;
                                skip_count = 16'd4;
                                phase      = PH_CAPTURE;
                            end
                            else if (skip_count != 0)
                                phase = PH_RDSKIP;
                            else
                                record_done();
                        end
                    end
                    PH_RDSKIP:
                    begin
                        skip_count = skip_count - 16'd1;
                        if (skip_count == 0)
                            record_done();
                    end
                    PH_CAPTURE:
                    begin
                        address    = {address[23:0], b};
                        skip_count = skip_count - 16'd1;
                        if (skip_count == 0)
                        begin
                            found = 1'b1;
                            phase = PH_DONE;
                        end
                    end
                    default:
                        ;
                endcase
                position = position + 10'd1;
            end
            if (last)
            begin
                if (position < HEADER_BYTES)
                    res.status = ST_TOO_SHORT;
                else if (!flags_ok)
                    res.status = ST_NOT_ANSWER;
                else if (!id_ok())
                    res.status = ST_ID_MISMATCH;
                else if (found)
                    res.status = ST_FOUND;
                else
                    res.status = ST_NO_A_RECORD;
                res.address = (res.status == ST_FOUND) ? address : 32'h0;
                res.id      = hdr_id;
                lookups.push_back(res);
                clear_message();
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task match_result(logic [2:0] status, logic [31:0] addr, logic [15:0] id);
            a_lookup_t exp;
            if (lookups.size() == 0)
            begin
                report($sformatf("result with no lookup pending, status %0d", status));
                return;
            end
            exp = lookups.pop_front();
            if (status !== exp.status)
                report($sformatf("status %0d, expected %0d", status, exp.status));
            if (addr !== exp.address)
                report($sformatf("address %h, expected %h", addr, exp.address));
            if (id !== exp.id)
                report($sformatf("response id %h, expected %h", id, exp.id));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    drap_byte_if   byte_ch();
    drap_result_if result_ch();

    a_record_board board = new();
    logic [7:0]    frame[$];
    bit            calm;
    int            hold_cnt;
    int            stall_cycles;
    int            bytes_sent;

    dns_response_a_record_parser_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_in    (byte_ch),
        .result_out (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
                board.take_byte(byte_ch.data_byte, byte_ch.last_byte);
            if (result_ch.valid && result_ch.ready)
                board.match_result(result_ch.status, result_ch.ipv4_address,
                                   result_ch.response_id);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("dns_response_a_record_parser_core_tb NOT OK");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // result sink: random stalls, or a long hold-off while hold_cnt runs down
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                result_ch.ready <= 1'b0;
            else if (hold_cnt > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cnt--;
            end
            else
                result_ch.ready <= calm || ($urandom_range(99) >= 31);
        end
    end

    function automatic void push_word(logic [15:0] w);
        frame.push_back(w[15:8]);
        frame.push_back(w[7:0]);
    endfunction

    function automatic void push_random(int n);
        repeat (n) frame.push_back(8'($urandom));
    endfunction

    function automatic void push_name();
        int kind;
        int labels;
        int len;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            frame.push_back(PTR_MASK | 8'($urandom_range(63)));
            frame.push_back(8'($urandom));
        end
        else
        begin
            labels = (kind < 42) ? 0 : $urandom_range(1, 3);
            repeat (labels)
            begin
                len = ($urandom_range(99) < 4) ? $urandom_range(8'h40, 8'hBF)
                                               : $urandom_range(1, 10);
                frame.push_back(8'(len));
                push_random(len);
            end
            if (kind < 55 && labels > 0)
            begin
                frame.push_back(PTR_MASK | 8'($urandom_range(63)));
                frame.push_back(8'($urandom));
            end
            else
                frame.push_back(8'h00);
        end
    endfunction

    function automatic void build_noise(int max_len);
        frame.delete();
        push_random($urandom_range(1, max_len));
    endfunction

    function automatic void build_response(logic [15:0] exp_id, bit oversize);
        logic [15:0] qd;
        logic [15:0] an;
        logic [15:0] rtype;
        logic [15:0] rclass;
        int          rdlen;
        int          r;
        int          target;
        frame.delete();
        push_word(($urandom_range(99) < 75) ? exp_id - 16'($urandom_range(0, 4))
                                            : 16'($urandom));
        frame.push_back(($urandom_range(99) < 88) ? (8'($urandom) | QR_MASK)
                                                  : (8'($urandom) & ~QR_MASK));
        frame.push_back(($urandom_range(99) < 85) ? (8'($urandom) & ~RCODE_MASK)
                                                  : 8'($urandom));
        qd = ($urandom_range(99) < 90) ? 16'($urandom_range(0, 2)) : 16'($urandom);
        r  = $urandom_range(99);
        an = (r < 8) ? 16'd0 : (r < 12) ? 16'($urandom) : 16'($urandom_range(1, 3));
        push_word(qd);
        push_word(an);
        push_random(4);
        for (int i = 0; i < qd && i < 2; i++)
        begin
            push_name();
            push_random(QUESTION_TAIL);
        end
        for (int i = 0; i < an && i < 3; i++)
        begin
            push_name();
            r      = $urandom_range(99);
            rtype  = (r < 55) ? TYPE_A : (r < 70) ? 16'd5 : (r < 85) ? 16'd28
                                                                    : 16'($urandom);
            rclass = ($urandom_range(99) < 85) ? CLASS_IN : 16'($urandom);
            rdlen  = (rtype == TYPE_A && rclass == CLASS_IN && $urandom_range(99) < 90)
                     ? 4 : $urandom_range(0, 8);
            push_word(rtype);
            push_word(rclass);
            push_random(4);
            push_word(16'(rdlen));
            push_random(rdlen);
        end
        r = $urandom_range(99);
        if (r < 8)
        begin
            target = $urandom_range(1, frame.size());
            while (frame.size() > target)
                void'(frame.pop_back());
        end
        else if (r < 15)
            push_random($urandom_range(1, 12));
        if (oversize)
        begin
            target = $urandom_range(MAX_PACKET_BYTES - 8, MAX_PACKET_BYTES + 90);
            while (frame.size() < target)
                frame.push_back(8'($urandom));
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        while (!calm && $urandom_range(99) < 31)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
        bytes_sent += frame.size();
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (board.lookups.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] id_value, logic [1:0] window);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXPECTED_ID;
        cfg_data  <= id_value;
        @(posedge clk);
        cfg_index <= CFG_ID_WINDOW;
        cfg_data  <= {14'b0, window};
        @(posedge clk);
        cfg_we <= 1'b0;
        board.expected_id = id_value;
        board.id_window   = window;
    endtask

    initial
    begin
        logic [15:0] phase_ids[PHASES];
        logic [1:0]  phase_windows[PHASES];
        int          msgs;
        int          start_bytes;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_EXPECTED_ID;
        cfg_data           = '0;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = '0;
        byte_ch.last_byte  = 1'b0;
        calm               = 1'b0;
        hold_cnt           = 0;
        stall_cycles       = 0;
        bytes_sent         = 0;
        phase_ids     = '{16'h0000, 16'hFFFF, 16'h0001, 16'($urandom), 16'h8000, 16'h0000};
        phase_windows = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd0, 2'd3};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte message, then the smallest response that carries an address
        frame = '{8'hFF};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h81, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'h00, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame();

        for (int p = 0; p < PHASES; p++)
        begin
            byte_ch.valid <= 1'b0;
            wait_drained();
            set_config(phase_ids[p], phase_windows[p]);
            calm = (p == 2);
            if (p == 3)
                hold_cnt = HOLD_CYCLES;
            msgs        = 0;
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES || msgs < MIN_MESSAGES)
            begin
                if (p == 3 && msgs < 16)
                    build_noise(6);
                else if (p == 4 && msgs == 1)
                    build_response(phase_ids[p], 1'b1);
                else if ($urandom_range(99) < 12)
                    build_noise(24);
                else
                    build_response(phase_ids[p], 1'b0);
                send_frame();
                msgs++;
            end
        end

        byte_ch.valid <= 1'b0;
        wait_drained();
        if (board.errors == 0 && board.lookups.size() == 0)
            $display("dns_response_a_record_parser_core_tb OK");
        else
            $display("dns_response_a_record_parser_core_tb NOT OK");
        $finish;
    end

endmodule
